// ===== design/ucts_pkg.sv =====
package ucts_pkg;

    // width of the transfer length and byte counters
    localparam int LENGTH_BITS = 16;

    localparam logic [7:0] DIR_IN_BIT   = 8'h80;
    localparam logic [6:0] PACKET_MIN   = 7'd8;
    localparam logic [6:0] PACKET_MAX   = 7'd64;
    localparam logic [6:0] SETUP_BYTES  = 7'd8;
    localparam logic [6:0] PACKET_RESET = 7'd8;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SETUP  = 3'd1,
        PH_DATA   = 3'd2,
        PH_STATUS = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        ACT_TOKEN  = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_REJECT = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        PID_SETUP = 2'd0,
        PID_IN    = 2'd1,
        PID_OUT   = 2'd2
    } t_pid;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DISC  = 2'd1,
        ST_STALL = 2'd2,
        ST_ERROR = 2'd3
    } t_status;

    typedef enum logic {
        FUNC_START  = 1'b0,
        FUNC_RESULT = 1'b1
    } t_func;

    // one input item
    typedef struct packed {
        logic        func;
        logic [7:0]  req_type;
        logic [7:0]  request;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] length;
        logic [1:0]  token_status;
        logic [6:0]  received_len;
    } t_item;

    // one result item
    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  pid;
        logic        toggle;
        logic        write_before;
        logic [15:0] data_offset;
        logic [6:0]  data_len;
        logic [63:0] setup_word;
        logic [1:0]  done_status;
        logic [15:0] moved_len;
    } t_result;

endpackage

// ===== design/ucts_in_stage.sv =====
module ucts_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ucts_pkg::t_item i_item,
    input  logic           i_out_ready,
    output logic           o_stall,
    output logic           o_fire,
    output ucts_pkg::t_item o_item
);

    logic            r_valid;
    ucts_pkg::t_item r_item;
    logic            w_accept;

    // item moves on when the result register can take it
    assign o_fire   = r_valid & i_out_ready;
    assign o_stall  = r_valid & ~i_out_ready;
    assign w_accept = i_valid & ~o_stall;
    assign o_item   = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_fire) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== design/ucts_engine.sv =====
module ucts_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ucts_pkg::t_item   i_item,
    input  logic [6:0]        i_ep0_max_packet,
    output ucts_pkg::t_result o_result
);

    localparam int LB = ucts_pkg::LENGTH_BITS;

    ucts_pkg::t_phase  r_phase, n_phase;
    logic              r_toggle, n_toggle;
    logic [LB-1:0]     r_left, n_left;
    logic [LB-1:0]     r_done, n_done;
    logic              r_dir_in, n_dir_in;
    logic [6:0]        r_chunk, n_chunk;

    logic [6:0]        w_mp;
    logic              w_busy;
    logic [LB-1:0]     w_len;
    logic [6:0]        w_got;
    logic [LB-1:0]     w_step;
    logic [LB-1:0]     w_left_tok;
    logic [LB-1:0]     w_done_tok;
    logic              w_tog_tok;
    logic              w_do_token;
    ucts_pkg::t_result w_res;

    // effective packet size, clamped to the legal range
    always_comb begin
        if (i_ep0_max_packet < ucts_pkg::PACKET_MIN) begin
            w_mp = ucts_pkg::PACKET_MIN;
        end else if (i_ep0_max_packet > ucts_pkg::PACKET_MAX) begin
            w_mp = ucts_pkg::PACKET_MAX;
        end else begin
            w_mp = i_ep0_max_packet;
        end
    end

    assign w_busy = (r_phase == ucts_pkg::PH_SETUP) || (r_phase == ucts_pkg::PH_DATA) ||
                    (r_phase == ucts_pkg::PH_STATUS);
    assign w_len  = i_item.length[LB-1:0];

    // bytes moved by the finished data token, long IN data clamped to the chunk
    always_comb begin
        if (r_dir_in) begin
            w_got = (i_item.received_len > r_chunk) ? r_chunk : i_item.received_len;
        end else begin
            w_got = r_chunk;
        end
        w_step = LB'(w_got);
    end

    // phase step and result
    always_comb begin
        n_phase    = r_phase;
        n_toggle   = r_toggle;
        n_left     = r_left;
        n_done     = r_done;
        n_dir_in   = r_dir_in;
        n_chunk    = r_chunk;
        w_left_tok = r_left;
        w_done_tok = r_done;
        w_tog_tok  = r_toggle;
        w_do_token = 1'b0;
        w_res      = '0;

        if (i_item.func == ucts_pkg::FUNC_START) begin
            if (w_busy) begin
                w_res.action = ucts_pkg::ACT_REJECT;
            end else begin
                n_dir_in = (i_item.req_type & ucts_pkg::DIR_IN_BIT) != 8'd0;
                n_left   = w_len;
                n_done   = '0;
                n_chunk  = '0;
                n_toggle = 1'b0;
                n_phase  = ucts_pkg::PH_SETUP;
                w_res.action       = ucts_pkg::ACT_TOKEN;
                w_res.pid          = ucts_pkg::PID_SETUP;
                w_res.toggle       = 1'b0;
                w_res.write_before = 1'b1;
                w_res.data_offset  = '0;
                w_res.data_len     = ucts_pkg::SETUP_BYTES;
                w_res.setup_word   = {16'(w_len), i_item.index, i_item.value,
                                      i_item.request, i_item.req_type};
            end
        end else if (!w_busy) begin
            n_phase      = ucts_pkg::PH_IDLE;
            w_res.action = ucts_pkg::ACT_REJECT;
        end else if (i_item.token_status != ucts_pkg::ST_OK) begin
            n_phase           = ucts_pkg::PH_IDLE;
            w_res.action      = ucts_pkg::ACT_FINISH;
            w_res.done_status = i_item.token_status;
            w_res.moved_len   = 16'(r_done);
        end else if (r_phase == ucts_pkg::PH_SETUP) begin
            n_toggle   = 1'b1;
            w_tog_tok  = 1'b1;
            w_do_token = 1'b1;
        end else if (r_phase == ucts_pkg::PH_DATA) begin
            n_toggle   = ~r_toggle;
            w_tog_tok  = ~r_toggle;
            w_done_tok = r_done + w_step;
            if (r_dir_in && (w_got < w_mp)) begin
                w_left_tok = '0;
            end else begin
                w_left_tok = r_left - w_step;
            end
            n_left     = w_left_tok;
            n_done     = w_done_tok;
            w_do_token = 1'b1;
        end else begin
            n_phase           = ucts_pkg::PH_IDLE;
            w_res.action      = ucts_pkg::ACT_FINISH;
            w_res.done_status = ucts_pkg::ST_OK;
            w_res.moved_len   = 16'(r_done);
        end

        // next data or status token
        if (w_do_token) begin
            w_res.action      = ucts_pkg::ACT_TOKEN;
            w_res.data_offset = 16'(w_done_tok);
            if (w_left_tok != '0) begin
                if (w_left_tok > LB'(w_mp)) begin
                    n_chunk = w_mp;
                end else begin
                    n_chunk = w_left_tok[6:0];
                end
                n_phase        = ucts_pkg::PH_DATA;
                w_res.toggle   = w_tog_tok;
                w_res.data_len = n_chunk;
                if (r_dir_in) begin
                    w_res.pid          = ucts_pkg::PID_IN;
                    w_res.write_before = 1'b0;
                end else begin
                    w_res.pid          = ucts_pkg::PID_OUT;
                    w_res.write_before = 1'b1;
                end
            end else begin
                n_phase        = ucts_pkg::PH_STATUS;
                w_res.toggle   = 1'b1;
                w_res.data_len = '0;
                if (r_dir_in) begin
                    w_res.pid          = ucts_pkg::PID_OUT;
                    w_res.write_before = 1'b1;
                end else begin
                    w_res.pid          = ucts_pkg::PID_IN;
                    w_res.write_before = 1'b0;
                end
            end
        end
    end

    assign o_result = w_res;

    // transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ucts_pkg::PH_IDLE;
            r_toggle <= 1'b0;
            r_left   <= '0;
            r_done   <= '0;
            r_dir_in <= 1'b0;
            r_chunk  <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_toggle <= n_toggle;
            r_left   <= n_left;
            r_done   <= n_done;
            r_dir_in <= n_dir_in;
            r_chunk  <= n_chunk;
        end
    end

endmodule

// ===== design/ucts_out_stage.sv =====
module ucts_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ucts_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_ready,
    output logic              o_valid,
    output ucts_pkg::t_result o_result
);

    logic              r_valid;
    ucts_pkg::t_result r_result;

    // free when empty or when the held item leaves this cycle
    assign o_ready  = ~r_valid | ~i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== design/usb_control_transfer_sequencer.sv =====
// Host-side USB control transfer sequencer. Each input item (a start request or
// the outcome of the last issued token) gives exactly one result item: the next
// token to issue, a finish with status and data stage length, or a rejection.
// One item is taken every clock cycle while o_stall is low; an item's result is
// presented once the item has passed the input register and the result
// register. The result register frees itself in the cycle its item is
// taken, so a full stream runs without gaps. ep0_max_packet is written through
// the configuration channel, whose ready is always high; write it only while no
// transfer is in flight.
module usb_control_transfer_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_req_type,
    input  logic [7:0]  i_request,
    input  logic [15:0] i_value,
    input  logic [15:0] i_index,
    input  logic [15:0] i_length,
    input  logic [1:0]  i_token_status,
    input  logic [6:0]  i_received_len,
    // result items
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_action,
    output logic [1:0]  o_pid,
    output logic        o_toggle,
    output logic        o_write_before,
    output logic [15:0] o_data_offset,
    output logic [6:0]  o_data_len,
    output logic [63:0] o_setup_word,
    output logic [1:0]  o_done_status,
    output logic [15:0] o_moved_len,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    ucts_pkg::t_item   w_in_item;
    ucts_pkg::t_item   w_item;
    ucts_pkg::t_result w_next;
    ucts_pkg::t_result w_out;
    logic              w_fire;
    logic              w_out_ready;
    logic [6:0]        r_ep0_max_packet;

    // packet size register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep0_max_packet <= ucts_pkg::PACKET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ep0_max_packet <= i_cfg_data;
        end
    end

    // gather input fields
    always_comb begin
        w_in_item.func         = i_func;
        w_in_item.req_type     = i_req_type;
        w_in_item.request      = i_request;
        w_in_item.value        = i_value;
        w_in_item.index        = i_index;
        w_in_item.length       = i_length;
        w_in_item.token_status = i_token_status;
        w_in_item.received_len = i_received_len;
    end

    ucts_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (w_in_item),
        .i_out_ready (w_out_ready),
        .o_stall     (o_stall),
        .o_fire      (w_fire),
        .o_item      (w_item)
    );

    ucts_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_item           (w_item),
        .i_ep0_max_packet (r_ep0_max_packet),
        .o_result         (w_next)
    );

    ucts_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_result (w_next),
        .i_stall  (i_stall),
        .o_ready  (w_out_ready),
        .o_valid  (o_valid),
        .o_result (w_out)
    );

    // spread result fields
    assign o_action       = w_out.action;
    assign o_pid          = w_out.pid;
    assign o_toggle       = w_out.toggle;
    assign o_write_before = w_out.write_before;
    assign o_data_offset  = w_out.data_offset;
    assign o_data_len     = w_out.data_len;
    assign o_setup_word   = w_out.setup_word;
    assign o_done_status  = w_out.done_status;
    assign o_moved_len    = w_out.moved_len;

endmodule
